// ----- rtl/core/ksrq_pkg.sv -----
// Shared types and constants for the key set with rank query block.
package ksrq_pkg;

    localparam int CAPACITY_DEFAULT  = 16;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_SELECT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL_NEXT,
        ST_SEL_CAND,
        ST_RESULT
    } state_t;

endpackage

// ----- rtl/core/key_set_with_rank_query.sv -----
// Bounded set of distinct keys with insert, erase, membership test and rank select.
//
// The block takes one request at a time and answers each with exactly one result.
// All work is done by a sequencer around a single key memory, which has one read
// port with a registered output, and one equality and one magnitude comparator.
// Insert, erase and membership test sweep every slot once before the result is
// registered. Rank select picks candidate slots in turn and sweeps all slots for
// each one to count smaller keys; a select with a rank not below the count skips
// the sweeps and goes straight to the result. Once a result sits in the output
// register, the next request is accepted while that result still waits to be
// taken.
module key_set_with_rank_query #(
    parameter int CAPACITY  = ksrq_pkg::CAPACITY_DEFAULT,
    parameter int KEY_WIDTH = ksrq_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_key,
    input  logic [3:0]  s_rank,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [31:0] m_selected_key,
    output logic [4:0]  m_item_count,
    output logic        m_table_full
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    ksrq_pkg::state_t state_reg, state_next;
    ksrq_pkg::cmd_t   cmd_reg, cmd_next;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [3:0]           rank_reg, rank_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 issue_reg, issue_next;
    logic                 pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_reg, free_next;
    logic [IDX_W-1:0]     outer_reg, outer_next;
    logic [KEY_WIDTH-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]     below_reg, below_next;
    logic                 res_success_reg, res_success_next;
    logic [31:0]          res_sel_reg, res_sel_next;
    logic                 res_full_reg, res_full_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_success_reg;
    logic [31:0]          m_selected_key_reg;
    logic [4:0]           m_item_count_reg;
    logic                 m_table_full_reg;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;

    logic                 out_load;
    logic [KEY_WIDTH-1:0] cmp_a;
    logic                 hit;
    logic                 free_hit;
    logic                 less;
    logic                 found_now;
    logic [IDX_W-1:0]     slot_now;
    logic                 free_now;
    logic [IDX_W-1:0]     free_slot_now;
    logic [CNT_W-1:0]     below_now;
    logic [63:0]          s_key_ext;
    logic [63:0]          cand_ext;
    logic [15:0]          count_ext;

    assign s_ready        = (state_reg == ksrq_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_success      = m_success_reg;
    assign m_selected_key = m_selected_key_reg;
    assign m_item_count   = m_item_count_reg;
    assign m_table_full   = m_table_full_reg;

    assign s_key_ext = {32'd0, s_key};
    assign cand_ext  = 64'(cand_reg);
    assign count_ext = 16'(count_reg);

    assign cmp_a    = (cmd_reg == ksrq_pkg::CMD_SELECT) ? cand_reg : key_reg;
    assign hit      = pipe_vld_reg && valid_reg[pipe_idx_reg] && (cmp_a == rd_reg);
    assign free_hit = pipe_vld_reg && !valid_reg[pipe_idx_reg];
    assign less     = pipe_vld_reg && valid_reg[pipe_idx_reg] && (cmp_a > rd_reg);

    assign found_now     = found_reg || hit;
    assign slot_now      = found_reg ? slot_reg : pipe_idx_reg;
    assign free_now      = free_found_reg || free_hit;
    assign free_slot_now = free_found_reg ? free_reg : pipe_idx_reg;
    assign below_now     = below_reg + CNT_W'(less);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= key_reg;
        end
        rd_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        rank_next        = rank_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        scan_idx_next    = scan_idx_reg;
        issue_next       = issue_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        free_found_next  = free_found_reg;
        free_next        = free_reg;
        outer_next       = outer_reg;
        cand_next        = cand_reg;
        below_next       = below_reg;
        res_success_next = res_success_reg;
        res_sel_next     = res_sel_reg;
        res_full_next    = res_full_reg;
        mem_we           = 1'b0;
        mem_waddr        = free_slot_now;
        mem_raddr        = scan_idx_reg;
        out_load         = 1'b0;

        unique case (state_reg)
            ksrq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next         = ksrq_pkg::cmd_t'(s_command);
                    key_next         = s_key_ext[KEY_WIDTH-1:0];
                    rank_next        = s_rank;
                    res_success_next = 1'b0;
                    res_sel_next     = 32'd0;
                    res_full_next    = 1'b0;
                    if (ksrq_pkg::cmd_t'(s_command) == ksrq_pkg::CMD_SELECT) begin
                        if (16'(s_rank) < count_ext) begin
                            outer_next = '0;
                            state_next = ksrq_pkg::ST_SEL_NEXT;
                        end else begin
                            state_next = ksrq_pkg::ST_RESULT;
                        end
                    end else begin
                        scan_idx_next   = '0;
                        issue_next      = 1'b1;
                        found_next      = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ksrq_pkg::ST_SCAN;
                    end
                end
            end
            ksrq_pkg::ST_SEL_NEXT: begin
                mem_raddr = outer_reg;
                if (valid_reg[outer_reg]) begin
                    state_next = ksrq_pkg::ST_SEL_CAND;
                end else if (outer_reg == LAST_IDX) begin
                    state_next = ksrq_pkg::ST_RESULT;
                end else begin
                    outer_next = outer_reg + IDX_W'(1);
                end
            end
            ksrq_pkg::ST_SEL_CAND: begin
                cand_next     = rd_reg;
                below_next    = '0;
                scan_idx_next = '0;
                issue_next    = 1'b1;
                state_next    = ksrq_pkg::ST_SCAN;
            end
            ksrq_pkg::ST_SCAN: begin
                if (issue_reg) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                if (hit && !found_reg) begin
                    found_next = 1'b1;
                    slot_next  = pipe_idx_reg;
                end
                if (free_hit && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_next       = pipe_idx_reg;
                end
                below_next = below_now;
                if (pipe_vld_reg && (pipe_idx_reg == LAST_IDX)) begin
                    state_next = ksrq_pkg::ST_RESULT;
                    unique case (cmd_reg)
                        ksrq_pkg::CMD_INSERT: begin
                            if (!found_now) begin
                                if (free_now) begin
                                    mem_we                    = 1'b1;
                                    valid_next[free_slot_now] = 1'b1;
                                    count_next                = count_reg + CNT_W'(1);
                                    res_success_next          = 1'b1;
                                end else begin
                                    res_full_next = 1'b1;
                                end
                            end
                        end
                        ksrq_pkg::CMD_ERASE: begin
                            if (found_now) begin
                                valid_next[slot_now] = 1'b0;
                                count_next           = count_reg - CNT_W'(1);
                                res_success_next     = 1'b1;
                            end
                        end
                        ksrq_pkg::CMD_TEST: begin
                            res_success_next = found_now;
                        end
                        ksrq_pkg::CMD_SELECT: begin
                            if (16'(below_now) == 16'(rank_reg)) begin
                                res_success_next = 1'b1;
                                res_sel_next     = cand_ext[31:0];
                            end else if (outer_reg != LAST_IDX) begin
                                outer_next = outer_reg + IDX_W'(1);
                                state_next = ksrq_pkg::ST_SEL_NEXT;
                            end
                        end
                        default: begin
                            state_next = ksrq_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            ksrq_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ksrq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ksrq_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ksrq_pkg::ST_IDLE;
            count_reg    <= '0;
            valid_reg    <= '0;
            issue_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            issue_reg    <= issue_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        rank_reg        <= rank_next;
        scan_idx_reg    <= scan_idx_next;
        pipe_idx_reg    <= pipe_idx_next;
        found_reg       <= found_next;
        slot_reg        <= slot_next;
        free_found_reg  <= free_found_next;
        free_reg        <= free_next;
        outer_reg       <= outer_next;
        cand_reg        <= cand_next;
        below_reg       <= below_next;
        res_success_reg <= res_success_next;
        res_sel_reg     <= res_sel_next;
        res_full_reg    <= res_full_next;
        if (out_load) begin
            m_success_reg      <= res_success_reg;
            m_selected_key_reg <= res_sel_reg;
            m_item_count_reg   <= count_ext[4:0];
            m_table_full_reg   <= res_full_reg;
        end
    end

endmodule

// ----- verif/key_set_with_rank_query_tb.sv -----
// Self-checking testbench for the key set with rank query block.
module key_set_with_rank_query_tb;

    localparam int SLOTS       = ksrq_pkg::CAPACITY_DEFAULT;
    localparam int STALL_LIMIT = 8000;
    localparam int TAIL_CYCLES = 400;
    localparam int PHASE_ITEMS = 270;

    typedef struct {
        ksrq_pkg::cmd_t cmd;
        logic [31:0]    key;
        logic [3:0]     rank;
    } request_t;

    typedef struct {
        bit          ok;
        logic [31:0] sel;
        logic [4:0]  count;
        bit          full;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = 2'd0;
    logic [31:0] s_key = 32'd0;
    logic [3:0]  s_rank = 4'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_success;
    logic [31:0] m_selected_key;
    logic [4:0]  m_item_count;
    logic        m_table_full;

    request_t    request_q[$];
    answer_t     answers_due[$];
    logic [31:0] live_keys[$];

    logic [31:0] slot_key[SLOTS];
    bit          slot_used[SLOTS];
    int unsigned keys_held = 0;

    bit          req_fire = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_queued = 0;
    int unsigned n_checked = 0;
    int unsigned stall_cycles = 0;
    int unsigned errors = 0;
    int unsigned cmd_seen[4] = '{default: 0};
    int unsigned full_hits = 0;
    int unsigned select_hits = 0;

    key_set_with_rank_query u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_key          (s_key),
        .s_rank         (s_rank),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_success      (m_success),
        .m_selected_key (m_selected_key),
        .m_item_count   (m_item_count),
        .m_table_full   (m_table_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic answer_t apply_to_set(request_t req);
        answer_t     ans;
        int          hit;
        int          free_slot;
        int unsigned below;
        ans = '{ok: 1'b0, sel: 32'd0, count: 5'd0, full: 1'b0};
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == req.key && hit < 0) begin
                hit = i;
            end
            if (!slot_used[i] && free_slot < 0) begin
                free_slot = i;
            end
        end
        case (req.cmd)
            ksrq_pkg::CMD_INSERT: begin
                if (hit < 0 && free_slot < 0) begin
                    ans.full = 1'b1;
                end else if (hit < 0) begin
                    slot_key[free_slot] = req.key;
                    slot_used[free_slot] = 1'b1;
                    keys_held++;
                    ans.ok = 1'b1;
                end
            end
            ksrq_pkg::CMD_ERASE: begin
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    keys_held--;
                    ans.ok = 1'b1;
                end
            end
            ksrq_pkg::CMD_TEST: begin
                ans.ok = (hit >= 0);
            end
            default: begin
                if (req.rank < keys_held) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        below = 0;
                        for (int j = 0; j < SLOTS; j++) begin
                            if (slot_used[i] && slot_used[j] && slot_key[i] > slot_key[j]) begin
                                below++;
                            end
                        end
                        if (slot_used[i] && below == req.rank && !ans.ok) begin
                            ans.sel = slot_key[i];
                            ans.ok = 1'b1;
                        end
                    end
                end
            end
        endcase
        ans.count = keys_held[4:0];
        return ans;
    endfunction

    // Queues a request and tracks which keys the set will hold once it has run.
    function automatic void queue_req(ksrq_pkg::cmd_t cmd, logic [31:0] key,
                                      logic [3:0] rank);
        int at;
        at = -1;
        foreach (live_keys[i]) begin
            if (live_keys[i] == key) begin
                at = i;
            end
        end
        if (cmd == ksrq_pkg::CMD_INSERT && at < 0 && live_keys.size() < SLOTS) begin
            live_keys.push_back(key);
        end else if (cmd == ksrq_pkg::CMD_ERASE && at >= 0) begin
            live_keys.delete(at);
        end
        request_q.push_back('{cmd: cmd, key: key, rank: rank});
        n_queued++;
    endfunction

    function automatic logic [31:0] pick_key(bit for_insert);
        logic [31:0] edge_keys[6];
        int unsigned r;
        edge_keys = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF};
        r = $urandom_range(99);
        if (for_insert ? r < 70 : (r < 15 || live_keys.size() == 0)) begin
            return $urandom;
        end else if (for_insert ? r < 85 : r < 30) begin
            return edge_keys[$urandom_range(5)];
        end else if (live_keys.size() != 0) begin
            return live_keys[$urandom_range(live_keys.size() - 1)];
        end
        return $urandom;
    endfunction

    // Random traffic drifts between filling and draining the set.
    function automatic void queue_random(bit filling);
        int unsigned r;
        int unsigned lim;
        r = $urandom_range(99);
        if (r < (filling ? 45 : 15)) begin
            queue_req(ksrq_pkg::CMD_INSERT, pick_key(1'b1), 4'($urandom));
        end else if (r < 60) begin
            queue_req(ksrq_pkg::CMD_ERASE, pick_key(1'b0), 4'($urandom));
        end else if (r < 75) begin
            queue_req(ksrq_pkg::CMD_TEST, pick_key(1'b0), 4'($urandom));
        end else begin
            lim = (live_keys.size() > 15) ? 15 : live_keys.size();
            if ($urandom_range(3) != 0) begin
                queue_req(ksrq_pkg::CMD_SELECT, $urandom, 4'($urandom_range(lim)));
            end else begin
                queue_req(ksrq_pkg::CMD_SELECT, $urandom, 4'($urandom));
            end
        end
    endfunction

    function automatic void note_error(string what, answer_t want, answer_t got);
        errors++;
        if (errors <= 10) begin
            $display("ERROR %s: expected ok=%0d key=%h count=%0d full=%0d",
                     what, want.ok, want.sel, want.count, want.full);
            $display("      actual ok=%0d key=%h count=%0d full=%0d",
                     got.ok, got.sel, got.count, got.full);
        end
    endfunction

    always @(negedge aclk) begin
        request_t nxt;
        if (aresetn) begin
            if (!s_valid || req_fire) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = request_q.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.cmd;
                    s_key <= nxt.key;
                    s_rank <= nxt.rank;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        answer_t  got;
        answer_t  want;
        request_t req;
        req_fire = aresetn && s_valid && s_ready;
        got = '{ok: m_success, sel: m_selected_key, count: m_item_count, full: m_table_full};
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                note_error("result with no request outstanding", got, got);
            end else begin
                want = answers_due.pop_front();
                n_checked++;
                if (got.ok !== want.ok || got.sel !== want.sel
                        || got.count !== want.count || got.full !== want.full) begin
                    note_error("result mismatch", want, got);
                end
            end
        end
        if (req_fire) begin
            req = '{cmd: ksrq_pkg::cmd_t'(s_command), key: s_key, rank: s_rank};
            want = apply_to_set(req);
            answers_due.push_back(want);
            cmd_seen[s_command]++;
            if (want.full) begin
                full_hits++;
            end
            if (req.cmd == ksrq_pkg::CMD_SELECT && want.ok) begin
                select_hits++;
            end
        end
        if (req_fire || (aresetn && m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(negedge aclk);
        end
        $display("key_set_with_rank_query_tb: errors");
        $finish;
    end

    initial begin
        int unsigned pcts[4][2];
        int unsigned run_len;
        bit          filling;
        pcts = '{'{0, 0}, '{48, 0}, '{0, 48}, '{23, 23}};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        queue_req(ksrq_pkg::CMD_SELECT, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_SELECT, 32'hFFFF_FFFF, 4'd15);
        queue_req(ksrq_pkg::CMD_ERASE, 32'h5, 4'd0);
        queue_req(ksrq_pkg::CMD_TEST, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_INSERT, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        queue_req(ksrq_pkg::CMD_INSERT, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_SELECT, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_SELECT, 32'h0, 4'd1);
        queue_req(ksrq_pkg::CMD_SELECT, 32'h0, 4'd2);
        for (int i = 1; i <= SLOTS - 2; i++) begin
            queue_req(ksrq_pkg::CMD_INSERT, 32'h0111_1111 * i + 32'h3, 4'd0);
        end
        queue_req(ksrq_pkg::CMD_INSERT, 32'h0001_2345, 4'd0);
        queue_req(ksrq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        queue_req(ksrq_pkg::CMD_SELECT, 32'h0, 4'd15);
        queue_req(ksrq_pkg::CMD_ERASE, 32'h0, 4'd0);
        queue_req(ksrq_pkg::CMD_ERASE, 32'h0, 4'd0);
        while (n_checked != n_queued) begin
            @(negedge aclk);
        end

        filling = 1'b1;
        run_len = 0;
        for (int ph = 0; ph < 4; ph++) begin
            @(posedge aclk);
            send_idle_pct = pcts[ph][0];
            recv_stall_pct = pcts[ph][1];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (run_len == 0) begin
                    filling = !filling;
                    run_len = $urandom_range(60, 30);
                end
                run_len--;
                queue_random(filling);
            end
            while (n_checked != n_queued) begin
                @(negedge aclk);
            end
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        errors += answers_due.size();
        $display("Checked %0d requests: %0d inserts, %0d erases, %0d tests, %0d selects.",
                 n_checked, cmd_seen[ksrq_pkg::CMD_INSERT], cmd_seen[ksrq_pkg::CMD_ERASE],
                 cmd_seen[ksrq_pkg::CMD_TEST], cmd_seen[ksrq_pkg::CMD_SELECT]);
        $display("Full-table rejects: %0d, successful selects: %0d, errors: %0d.",
                 full_hits, select_hits, errors);
        if (errors == 0) begin
            $display("key_set_with_rank_query_tb: clean");
        end else begin
            $display("key_set_with_rank_query_tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ksrq_pkg.sv
rtl/core/key_set_with_rank_query.sv
verif/key_set_with_rank_query_tb.sv
